FILE: hw/rtl/chunked_slot_allocator_macros.svh
// Assertion macros shared by the slot allocator RTL.
`ifndef CHUNKED_SLOT_ALLOCATOR_MACROS_SVH
`define CHUNKED_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/csa_pkg.sv
// Shared types and constants of the chunked slot allocator.
`default_nettype none

package csa_pkg;

    // Field widths of the stream payloads.
    localparam int CHUNK_FIELD_W = 3;
    localparam int SLOT_FIELD_W  = 6;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 7;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 16;

    // Request kinds.
    typedef enum logic [0:0] {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_REL_RD,
        S_REL_WR,
        S_SCAN,
        S_DRAIN,
        S_PICK,
        S_ALC_WR
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic pick;
        logic alc_commit;
        logic rel_commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/csa_ram.sv
// Generic simple dual-port RAM with a registered read port.
`default_nettype none

module csa_ram #(
    parameter int WIDTH = 71,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic [AW-1:0]        i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/csa_ctrl.sv
// Sequencing controller of the chunked slot allocator.
`default_nettype none

module csa_ctrl
    import csa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_cmd     i_in_cmd,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);
    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_cmd == CMD_RELEASE) ? S_REL_RD : S_SCAN;
                end
            end
            S_REL_RD: n_state = S_REL_WR;
            S_REL_WR: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_PICK;
            S_PICK:  n_state = S_ALC_WR;
            S_ALC_WR: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Command outputs. No request is taken while reset is held.
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
            end
            S_REL_WR: o_cmd.rel_commit = i_stat.out_free;
            S_SCAN:   o_cmd.scan_step  = 1'b1;
            S_PICK:   o_cmd.pick       = 1'b1;
            S_ALC_WR: o_cmd.alc_commit = i_stat.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/csa_dp.sv
// Datapath of the chunked slot allocator: chunk state, scan, pick and result register.
`default_nettype none

module csa_dp
    import csa_pkg::*;
#(
    parameter int NUM_CHUNKS      = 8,
    parameter int SLOTS_PER_CHUNK = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_stat                      o_stat,
    input  wire t_cmd                     i_in_cmd,
    input  wire logic [CHUNK_FIELD_W-1:0] i_in_chunk,
    input  wire logic [SLOT_FIELD_W-1:0]  i_in_slot,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [STATUS_W-1:0]           o_status,
    output logic [CHUNK_FIELD_W-1:0]      o_granted_chunk,
    output logic [SLOT_FIELD_W-1:0]       o_granted_slot,
    output logic                          o_chunk_created,
    output logic                          o_chunk_retired
);
    localparam int CW     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int SW     = (SLOTS_PER_CHUNK > 1) ? $clog2(SLOTS_PER_CHUNK) : 1;
    localparam int WORD_W = COUNT_W + SLOTS_PER_CHUNK;
    localparam logic [COUNT_W-1:0] SLOTS_C  = COUNT_W'(SLOTS_PER_CHUNK);
    localparam logic [COUNT_W-1:0] CHUNKS_C = COUNT_W'(NUM_CHUNKS);

    // Captured request.
    t_cmd                     r_cmd;
    logic [CHUNK_FIELD_W-1:0] r_rel_chunk;
    logic [SLOT_FIELD_W-1:0]  r_rel_slot;

    // Chunk live bits.
    logic [NUM_CHUNKS-1:0] r_live;

    // Scan pipeline and best candidate.
    logic [CW-1:0]              r_scan_idx;
    logic                       r_rd_vld;
    logic [CW-1:0]              r_rd_idx;
    logic                       r_best_vld;
    logic [COUNT_W-1:0]         r_best_cnt;
    logic [CW-1:0]              r_best_idx;
    logic [SLOTS_PER_CHUNK-1:0] r_best_map;

    // Chosen chunk for the allocation.
    logic [CW-1:0]              r_pick_idx;
    logic [COUNT_W-1:0]         r_pick_cnt;
    logic [SLOTS_PER_CHUNK-1:0] r_pick_map;
    logic                       r_pick_created;
    logic                       r_pick_fail;

    // Result register.
    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_out_status;
    logic [CHUNK_FIELD_W-1:0] r_out_chunk;
    logic [SLOT_FIELD_W-1:0]  r_out_slot;
    logic                     r_out_created;
    logic                     r_out_retired;

    // Memory ports.
    logic                       mem_we;
    logic [CW-1:0]              mem_waddr;
    logic [WORD_W-1:0]          mem_wdata;
    logic [CW-1:0]              mem_raddr;
    logic [WORD_W-1:0]          mem_rdata;
    logic [COUNT_W-1:0]         rd_cnt;
    logic [SLOTS_PER_CHUNK-1:0] rd_map;

    // Release decode.
    logic [COUNT_W-1:0]         rel_chunk_ext;
    logic [COUNT_W-1:0]         rel_slot_ext;
    logic [CW-1:0]              rel_idx;
    logic [SW-1:0]              rel_slot_idx;
    logic [SLOTS_PER_CHUNK-1:0] rel_mask;
    logic                       rel_ok;
    logic [COUNT_W-1:0]         rel_cnt;
    logic                       rel_retire;

    // Scan and allocation decode.
    logic                       scan_better;
    logic                       dead_found;
    logic [CW-1:0]              dead_idx;
    logic                       free_found;
    logic [SW-1:0]              free_slot;
    logic [SLOTS_PER_CHUNK-1:0] alc_mask;
    logic                       alc_ok;
    logic [COUNT_W-1:0]         pick_idx_ext;
    logic [COUNT_W-1:0]         free_slot_ext;
    logic                       out_free;

    // Per-chunk word: use count above the slot bitmap.
    csa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_CHUNKS)
    ) u_chunk_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_cnt = mem_rdata[WORD_W-1 -: COUNT_W];
    assign rd_map = mem_rdata[SLOTS_PER_CHUNK-1:0];

    // Release address and range checks.
    assign rel_chunk_ext = {{(COUNT_W-CHUNK_FIELD_W){1'b0}}, r_rel_chunk};
    assign rel_slot_ext  = {{(COUNT_W-SLOT_FIELD_W){1'b0}}, r_rel_slot};
    assign rel_idx       = rel_chunk_ext[CW-1:0];
    assign rel_slot_idx  = rel_slot_ext[SW-1:0];
    assign rel_mask      = SLOTS_PER_CHUNK'(1'b1) << rel_slot_idx;
    assign rel_ok        = (rel_chunk_ext < CHUNKS_C) && (rel_slot_ext < SLOTS_C)
                           && r_live[rel_idx] && (|(rd_map & rel_mask));
    assign rel_cnt       = rd_cnt - COUNT_W'(1);
    assign rel_retire    = (rel_cnt == '0);

    // Read address follows the scan counter, or the release chunk.
    assign mem_raddr = (r_cmd == CMD_RELEASE) ? rel_idx : r_scan_idx;

    // A returned chunk beats the best so far only with a strictly higher count.
    assign scan_better = r_rd_vld && r_live[r_rd_idx] && (rd_cnt < SLOTS_C)
                         && (!r_best_vld || (rd_cnt > r_best_cnt));

    // Lowest dead chunk.
    always_comb begin
        dead_found = 1'b0;
        dead_idx   = '0;
        for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
            if (!r_live[i]) begin
                dead_found = 1'b1;
                dead_idx   = CW'(i);
            end
        end
    end

    // Lowest free slot of the chosen chunk.
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOTS_PER_CHUNK - 1; i >= 0; i--) begin
            if (!r_pick_map[i]) begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
    end

    assign alc_mask      = SLOTS_PER_CHUNK'(1'b1) << free_slot;
    assign alc_ok        = !r_pick_fail && free_found;
    assign pick_idx_ext  = {{(COUNT_W-CW){1'b0}}, r_pick_idx};
    assign free_slot_ext = {{(COUNT_W-SW){1'b0}}, free_slot};

    // Write-back of the chunk word.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = rel_idx;
        mem_wdata = {rel_cnt, rd_map & ~rel_mask};
        if (i_cmd.alc_commit) begin
            mem_we    = alc_ok;
            mem_waddr = r_pick_idx;
            mem_wdata = {r_pick_cnt + COUNT_W'(1), r_pick_map | alc_mask};
        end else if (i_cmd.rel_commit) begin
            mem_we    = rel_ok;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // Control state: live bits, scan tags and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_rd_vld    <= 1'b0;
            r_best_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.capture) begin
                r_best_vld <= 1'b0;
            end else if (scan_better) begin
                r_best_vld <= 1'b1;
            end
            if (i_cmd.alc_commit && alc_ok) begin
                r_live[r_pick_idx] <= 1'b1;
            end else if (i_cmd.rel_commit && rel_ok && rel_retire) begin
                r_live[rel_idx] <= 1'b0;
            end
            if (i_cmd.alc_commit || i_cmd.rel_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd       <= i_in_cmd;
            r_rel_chunk <= i_in_chunk;
            r_rel_slot  <= i_in_slot;
            r_scan_idx  <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + CW'(1);
        end
        r_rd_idx <= r_scan_idx;

        if (scan_better) begin
            r_best_cnt <= rd_cnt;
            r_best_idx <= r_rd_idx;
            r_best_map <= rd_map;
        end

        // Choose the fullest live chunk, else bring up the lowest dead one.
        if (i_cmd.pick) begin
            if (r_best_vld) begin
                r_pick_idx     <= r_best_idx;
                r_pick_cnt     <= r_best_cnt;
                r_pick_map     <= r_best_map;
                r_pick_created <= 1'b0;
                r_pick_fail    <= 1'b0;
            end else begin
                r_pick_idx     <= dead_idx;
                r_pick_cnt     <= '0;
                r_pick_map     <= '0;
                r_pick_created <= dead_found;
                r_pick_fail    <= !dead_found;
            end
        end

        // Result fields.
        if (i_cmd.alc_commit) begin
            r_out_status  <= alc_ok ? ST_OK : ST_NO_SPACE;
            r_out_chunk   <= alc_ok ? pick_idx_ext[CHUNK_FIELD_W-1:0] : '0;
            r_out_slot    <= alc_ok ? free_slot_ext[SLOT_FIELD_W-1:0] : '0;
            r_out_created <= alc_ok && r_pick_created;
            r_out_retired <= 1'b0;
        end else if (i_cmd.rel_commit) begin
            r_out_status  <= rel_ok ? ST_OK : ST_BAD_RELEASE;
            r_out_chunk   <= '0;
            r_out_slot    <= '0;
            r_out_created <= 1'b0;
            r_out_retired <= rel_ok && rel_retire;
        end
    end

    assign o_stat.scan_last = (r_scan_idx == CW'(NUM_CHUNKS - 1));
    assign o_stat.out_free  = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_chunk = r_out_chunk;
    assign o_granted_slot  = r_out_slot;
    assign o_chunk_created = r_out_created;
    assign o_chunk_retired = r_out_retired;

endmodule

`default_nettype wire

FILE: hw/rtl/chunked_slot_allocator.sv
// Chunked slot allocator: bitmap chunks, allocations go to the fullest live chunk.
//
// Requests arrive on the s_axis stream: tuser selects allocate or release, tdata
// names the chunk and slot of a release. Each request gives one result on the
// m_axis stream: a status, the granted chunk and slot, and created/retired flags.
// An allocate reads every chunk's use count and bitmap from the chunk memory, one
// chunk per cycle, then picks a chunk and its lowest free slot and writes that word back.
// A release reads and writes back one chunk word.
// One request is in work at a time; the next one is taken as soon as the block
// returns to idle, even while the previous result still waits in the output
// register. When the receiver stalls with a result pending, the next request
// finishes its work and holds in its write-back step until that register frees.
// A synchronous active-low reset marks all chunks dead and drops any pending
// result; the chunk memory needs no clearing pass, since a dead chunk's word is
// never used and bringing a chunk up writes its word.
`default_nettype none

module chunked_slot_allocator
    import csa_pkg::*;
#(
    parameter int NUM_CHUNKS      = 8,
    parameter int SLOTS_PER_CHUNK = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // release_chunk[2:0], release_slot[8:3]
    input  wire logic                   s_axis_tuser,  // command[0]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // status[1:0], granted_chunk[4:2],
                                                       // granted_slot[10:5], chunk_created[11],
                                                       // chunk_retired[12]
);
`include "chunked_slot_allocator_macros.svh"

    t_dp_cmd dp_cmd;
    t_dp_stat dp_stat;
    t_cmd in_cmd;

    logic [STATUS_W-1:0]      out_status;
    logic [CHUNK_FIELD_W-1:0] out_chunk;
    logic [SLOT_FIELD_W-1:0]  out_slot;
    logic                     out_created;
    logic                     out_retired;

    assign in_cmd = t_cmd'(s_axis_tuser);

    // Sequencer.
    csa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (in_cmd),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Chunk state and result register.
    csa_dp #(
        .NUM_CHUNKS      (NUM_CHUNKS),
        .SLOTS_PER_CHUNK (SLOTS_PER_CHUNK)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_in_cmd        (in_cmd),
        .i_in_chunk      (s_axis_tdata[CHUNK_FIELD_W-1:0]),
        .i_in_slot       (s_axis_tdata[CHUNK_FIELD_W +: SLOT_FIELD_W]),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_status        (out_status),
        .o_granted_chunk (out_chunk),
        .o_granted_slot  (out_slot),
        .o_chunk_created (out_created),
        .o_chunk_retired (out_retired)
    );

    // Pack the result fields from the lowest bit up.
    assign m_axis_tdata = {3'b000, out_retired, out_created, out_slot, out_chunk, out_status};

    // Checks on the controller and datapath cooperation.
    `CSA_ASSERT_NOW(a_commit_needs_room, i_clk, i_rst_n,
        dp_cmd.alc_commit || dp_cmd.rel_commit, dp_stat.out_free,
        "result committed while the output register is still occupied")
    `CSA_ASSERT_NEXT(a_commit_shows_result, i_clk, i_rst_n,
        dp_cmd.alc_commit || dp_cmd.rel_commit, m_axis_tvalid,
        "committed result did not appear on the output")
    `CSA_ASSERT_NOW(a_one_command, i_clk, i_rst_n,
        1'b1, $onehot0(dp_cmd),
        "controller issued more than one datapath command")
    `CSA_ASSERT_NEXT(a_capture_starts_work, i_clk, i_rst_n,
        dp_cmd.capture, !s_axis_tready,
        "accepted request did not take the block out of idle")

endmodule

`default_nettype wire

FILE: tb/chunked_slot_allocator_tb.sv
// Stream testbench for the chunked slot allocator with a self-checking pool predictor.
`timescale 1ns / 100ps

module chunked_slot_allocator_tb
    import csa_pkg::*;
();

    localparam int N_CHUNKS    = 8;
    localparam int N_SLOTS     = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int CALM_FROM   = 2000;
    localparam int CALM_TO     = 4000;

    // One request as the sender sees it.
    typedef struct packed {
        t_cmd                     cmd;
        logic [CHUNK_FIELD_W-1:0] chunk;
        logic [SLOT_FIELD_W-1:0]  slot;
    } t_req;

    // One result of the allocator.
    typedef struct packed {
        logic                     retired;
        logic                     created;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [CHUNK_FIELD_W-1:0] chunk;
        logic [STATUS_W-1:0]      status;
    } t_grant;

    // Live bits, use counts and slot bitmaps of all chunks.
    typedef struct packed {
        logic [N_CHUNKS-1:0]                 live;
        logic [N_CHUNKS-1:0][COUNT_W-1:0]    used;
        logic [N_CHUNKS-1:0][N_SLOTS-1:0]    map;
    } t_pool;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // release_chunk[2:0], release_slot[8:3]
    logic                   s_axis_tuser = 1'b0; // command[0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // status[1:0], granted_chunk[4:2],
                                                 // granted_slot[10:5], chunk_created[11],
                                                 // chunk_retired[12]

    t_req   pending_reqs[$];
    t_grant want_grants[$];
    t_pool  gen_pool;
    t_pool  model_pool;
    t_req   next_req;
    t_req   seen_req;
    t_grant got;
    t_grant want;
    int     cyc = 0;
    int     n_queued = 0;
    int     n_accepted = 0;
    int     n_checked = 0;
    int     n_bad = 0;
    int     quiet = 0;
    int     hold_left = 0;
    bit     held = 1'b0;
    bit     req_taken = 1'b0;

    chunked_slot_allocator #(
        .NUM_CHUNKS      (N_CHUNKS),
        .SLOTS_PER_CHUNK (N_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one request to a pool and returns the result it gives.
    function automatic t_grant apply_request(input t_req rq, inout t_pool p);
        t_grant g;
        int     pick;
        int     s;
        bit     fresh;
        g = '0;
        pick = -1;
        s = -1;
        fresh = 1'b0;
        if (rq.cmd == CMD_ALLOC) begin
            // Fullest live chunk that still has room, lowest number on a tie.
            for (int i = 0; i < N_CHUNKS; i++) begin
                if (p.live[i] && p.used[i] < N_SLOTS) begin
                    if (pick < 0 || p.used[i] > p.used[pick])
                        pick = i;
                end
            end
            // Otherwise bring up the lowest dead chunk.
            if (pick < 0) begin
                for (int i = N_CHUNKS - 1; i >= 0; i--) begin
                    if (!p.live[i])
                        pick = i;
                end
                fresh = (pick >= 0);
            end
            if (pick < 0) begin
                g.status = ST_NO_SPACE;
                return g;
            end
            for (int j = N_SLOTS - 1; j >= 0; j--) begin
                if (!p.map[pick][j])
                    s = j;
            end
            if (s < 0) begin
                g.status = ST_NO_SPACE;
                return g;
            end
            if (fresh) begin
                p.live[pick] = 1'b1;
                p.used[pick] = '0;
                p.map[pick]  = '0;
            end
            p.map[pick][s] = 1'b1;
            p.used[pick]   = p.used[pick] + 1'b1;
            g.status  = ST_OK;
            g.chunk   = CHUNK_FIELD_W'(pick);
            g.slot    = SLOT_FIELD_W'(s);
            g.created = fresh;
        end else if (int'(rq.chunk) >= N_CHUNKS || int'(rq.slot) >= N_SLOTS ||
                     !p.live[rq.chunk] || !p.map[rq.chunk][rq.slot]) begin
            g.status = ST_BAD_RELEASE;
        end else begin
            p.map[rq.chunk][rq.slot] = 1'b0;
            p.used[rq.chunk] = p.used[rq.chunk] - 1'b1;
            // An emptied chunk goes dead with a clean bitmap.
            if (p.used[rq.chunk] == '0) begin
                p.live[rq.chunk] = 1'b0;
                p.map[rq.chunk]  = '0;
                g.retired = 1'b1;
            end
            g.status = ST_OK;
        end
        return g;
    endfunction

    // Picks a random taken slot of the pool; returns 0 when nothing is taken.
    function automatic bit pick_taken(input t_pool p, output logic [CHUNK_FIELD_W-1:0] ch,
                                      output logic [SLOT_FIELD_W-1:0] sl);
        int cands[$];
        int bits[$];
        int c;
        ch = '0;
        sl = '0;
        for (int i = 0; i < N_CHUNKS; i++) begin
            if (p.live[i] && p.used[i] != '0)
                cands.push_back(i);
        end
        if (cands.size() == 0)
            return 1'b0;
        c = cands[$urandom_range(0, cands.size() - 1)];
        for (int j = 0; j < N_SLOTS; j++) begin
            if (p.map[c][j])
                bits.push_back(j);
        end
        ch = CHUNK_FIELD_W'(c);
        sl = SLOT_FIELD_W'(bits[$urandom_range(0, bits.size() - 1)]);
        return 1'b1;
    endfunction

    // Queues one request and tracks its effect on the pool seen by the generator.
    task automatic add_req(input t_cmd c, input logic [CHUNK_FIELD_W-1:0] ch,
                           input logic [SLOT_FIELD_W-1:0] sl);
        t_req rq;
        rq.cmd   = c;
        rq.chunk = ch;
        rq.slot  = sl;
        pending_reqs.push_back(rq);
        void'(apply_request(rq, gen_pool));
    endtask

    // A release of a slot that is taken, or an allocate when the pool is empty.
    task automatic add_good_release();
        logic [CHUNK_FIELD_W-1:0] ch;
        logic [SLOT_FIELD_W-1:0]  sl;
        if (pick_taken(gen_pool, ch, sl))
            add_req(CMD_RELEASE, ch, sl);
        else
            add_req(CMD_ALLOC, ch, sl);
    endtask

    // Sender: a new request is offered at the falling edge once the last one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && cyc > 8 && (!s_axis_tvalid || req_taken)) begin
            if (pending_reqs.size() != 0 &&
                ((cyc >= CALM_FROM && cyc < CALM_TO) || $urandom_range(0, 99) >= 28)) begin
                next_req = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= next_req.cmd;
                s_axis_tdata  <= {{(IN_TDATA_W - CHUNK_FIELD_W - SLOT_FIELD_W){1'b0}},
                                  next_req.slot, next_req.chunk};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a calm window.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!held && n_checked >= 60) begin
            held <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (cyc >= CALM_FROM && cyc < CALM_TO) ||
                             ($urandom_range(0, 99) >= 28);
        end
    end

    // Monitor: checks each result transfer and predicts each request transfer.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        req_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_grant'(m_axis_tdata[12:0]);
                if (want_grants.size() == 0) begin
                    n_bad <= n_bad + 1;
                    if (n_bad < 10) begin
                        $write("%0t: result with nothing expected: status %0d chunk %0d",
                               $realtime, got.status, got.chunk);
                        $display(" slot %0d created %0b retired %0b", got.slot,
                                 got.created, got.retired);
                    end
                end else begin
                    want = want_grants.pop_front();
                    n_checked <= n_checked + 1;
                    if (got.status != want.status || got.chunk != want.chunk ||
                        got.slot != want.slot || got.created != want.created ||
                        got.retired != want.retired) begin
                        n_bad <= n_bad + 1;
                        if (n_bad < 10) begin
                            $write("%0t: mismatch: expected status %0d chunk %0d slot %0d",
                                   $realtime, want.status, want.chunk, want.slot);
                            $write(" created %0b retired %0b,", want.created,
                                   want.retired);
                            $write(" got status %0d chunk %0d slot %0d", got.status,
                                   got.chunk, got.slot);
                            $display(" created %0b retired %0b", got.created,
                                     got.retired);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen_req.cmd   = t_cmd'(s_axis_tuser);
                seen_req.chunk = s_axis_tdata[CHUNK_FIELD_W-1:0];
                seen_req.slot  = s_axis_tdata[CHUNK_FIELD_W +: SLOT_FIELD_W];
                want_grants.push_back(apply_request(seen_req, model_pool));
                n_accepted <= n_accepted + 1;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet <= 0;
            end else if (quiet >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    // Reset, stimulus and end of run.
    initial begin
        int r;
        int free_left;
        gen_pool   = '0;
        model_pool = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: releases into an empty pool, first grants, unset slot, retire.
        add_req(CMD_RELEASE, 3'd7, 6'd63);
        add_req(CMD_RELEASE, 3'd0, 6'd0);
        add_req(CMD_ALLOC,   3'd7, 6'd63);
        add_req(CMD_ALLOC,   3'd0, 6'd0);
        add_req(CMD_RELEASE, 3'd0, 6'd5);
        add_req(CMD_RELEASE, 3'd0, 6'd0);
        add_req(CMD_ALLOC,   3'd5, 6'd42);
        add_req(CMD_RELEASE, 3'd0, 6'd0);
        add_req(CMD_RELEASE, 3'd0, 6'd1);
        add_req(CMD_RELEASE, 3'd0, 6'd1);
        add_req(CMD_ALLOC,   3'd2, 6'd21);
        add_req(CMD_ALLOC,   3'd0, 6'd0);
        add_req(CMD_RELEASE, 3'd1, 6'd0);
        add_req(CMD_RELEASE, 3'd0, 6'd63);
        add_req(CMD_RELEASE, 3'd0, 6'd1);
        add_req(CMD_RELEASE, 3'd0, 6'd0);

        // Random mix that grows the pool.
        for (int k = 0; k < 20; k++) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                add_req(CMD_ALLOC, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
            else if (r < 88)
                add_good_release();
            else
                add_req(CMD_RELEASE, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
        end

        // Fill every chunk, then run out of chunks.
        free_left = 1;
        while (free_left > 0) begin
            if ($urandom_range(0, 99) < 2)
                add_good_release();
            else
                add_req(CMD_ALLOC, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
            free_left = 0;
            for (int i = 0; i < N_CHUNKS; i++)
                free_left += gen_pool.live[i] ? N_SLOTS - int'(gen_pool.used[i]) : N_SLOTS;
        end
        for (int k = 0; k < 4; k++)
            add_req(CMD_ALLOC, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
        add_req(CMD_RELEASE, 3'd7, 6'd63);
        add_req(CMD_ALLOC, 3'd0, 6'd0);
        add_req(CMD_ALLOC, 3'd0, 6'd0);

        // Releases with allocations between them on the full pool, so counts tie.
        for (int k = 0; k < 15; k++) begin
            r = $urandom_range(0, 99);
            if (r < 20)
                add_req(CMD_ALLOC, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
            else if (r < 90)
                add_good_release();
            else
                add_req(CMD_RELEASE, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
        end
        n_queued = pending_reqs.size();

        // Wait for every request to be taken and every result checked.
        while (n_accepted != n_queued || n_checked != n_accepted)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_bad == 0 && want_grants.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/csa_pkg.sv
hw/rtl/csa_ram.sv
hw/rtl/csa_ctrl.sv
hw/rtl/csa_dp.sv
hw/rtl/chunked_slot_allocator.sv
tb/chunked_slot_allocator_tb.sv
